/* rtl/sitda_pkg.sv */
// shared types and constants for the signed integer to decimal ascii block
// no dependencies; imported by every module of the block
package sitda_pkg;

   localparam int MaxDigits = 10;
   localparam int DigitWidth = 4;
   localparam int DigitIndexWidth = $clog2(MaxDigits + 1);
   localparam int QueueDepth = 2;
   localparam int QueuePtrWidth = $clog2(QueueDepth);

   localparam logic [7:0] CharZero = 8'h30;
   localparam logic [7:0] CharMinus = 8'h2D;

   // floor(x / 10) == (x * Recip10) >> Recip10Shift for every 32-bit x
   localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;
   localparam int Recip10Shift = 35;

   typedef logic [DigitWidth-1:0] digit_type;

   typedef struct packed {
      logic neg;
      logic [DigitIndexWidth-1:0] ndig;
      logic [MaxDigits-1:0][DigitWidth-1:0] digits;  // least significant at index 0
   } entry_type;

   typedef enum logic [1:0] {
      FRONT_IDLE,
      FRONT_DIVIDE,
      FRONT_HOLD
   } front_state_type;

endpackage

/* rtl/sitda_front.sv */
// front end: takes a value, splits its magnitude into decimal digits
// one digit per cycle by reciprocal multiply; depends on sitda_pkg
module sitda_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [31:0]            req_value,
   input  logic                   queue_full,
   output logic                   push,
   output sitda_pkg::entry_type   push_entry
);
   import sitda_pkg::*;

   front_state_type state_ff, state_in;
   logic [31:0] mag_ff;
   logic neg_ff;
   logic [DigitIndexWidth-1:0] nd_ff;
   digit_type digs_ff [MaxDigits];
   digit_type digs_in [MaxDigits];

   logic [63:0] prod;
   logic [28:0] quot;
   logic [31:0] times10;
   logic [31:0] remw;
   digit_type rem;
   logic quot_zero;
   logic accept;

   assign prod = {32'd0, mag_ff} * {32'd0, Recip10};
   assign quot = prod[63:Recip10Shift];
   assign times10 = {quot[28:0], 3'b000} + {2'b00, quot[28:0], 1'b0};
   assign remw = mag_ff - times10;
   assign rem = remw[DigitWidth-1:0];
   assign quot_zero = (quot == 29'd0);
   assign accept = start && (state_ff == FRONT_IDLE);

   always_comb begin
      for (int i = 0; i < MaxDigits; i++) begin
         digs_in[i] = (nd_ff == DigitIndexWidth'(i)) ? rem : digs_ff[i];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FRONT_IDLE: begin
            if (start) state_in = FRONT_DIVIDE;
         end
         FRONT_DIVIDE: begin
            if (quot_zero) state_in = queue_full ? FRONT_HOLD : FRONT_IDLE;
         end
         FRONT_HOLD: begin
            if (!queue_full) state_in = FRONT_IDLE;
         end
         default: state_in = FRONT_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy = 1'b1;
      push = 1'b0;
      push_entry.neg = neg_ff;
      push_entry.ndig = nd_ff;
      for (int i = 0; i < MaxDigits; i++) push_entry.digits[i] = digs_ff[i];
      case (state_ff)
         FRONT_IDLE: begin
            busy = 1'b0;
         end
         FRONT_DIVIDE: begin
            push = quot_zero && !queue_full;
            push_entry.ndig = nd_ff + 1'b1;
            for (int i = 0; i < MaxDigits; i++) push_entry.digits[i] = digs_in[i];
         end
         FRONT_HOLD: begin
            push = !queue_full;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FRONT_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         neg_ff <= req_value[31];
         mag_ff <= req_value[31] ? (32'd0 - req_value) : req_value;
         nd_ff <= '0;
      end else if (state_ff == FRONT_DIVIDE && !quot_zero) begin
         mag_ff <= {3'b000, quot};
         nd_ff <= nd_ff + 1'b1;
      end else if (state_ff == FRONT_DIVIDE) begin
         nd_ff <= nd_ff + 1'b1;
      end
      if (state_ff == FRONT_DIVIDE) begin
         for (int i = 0; i < MaxDigits; i++) digs_ff[i] <= digs_in[i];
      end
   end

endmodule

/* rtl/sitda_queue.sv */
// short queue of converted digit sets between front and back
// depends on sitda_pkg
module sitda_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  sitda_pkg::entry_type   push_entry,
   output logic                   full,
   input  logic                   pop,
   output logic                   head_valid,
   output sitda_pkg::entry_type   head_entry
);
   import sitda_pkg::*;

   entry_type slot_ff [QueueDepth];
   logic [QueuePtrWidth-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QueuePtrWidth:0] count_ff;

   assign full = (count_ff == (QueuePtrWidth + 1)'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

/* rtl/sitda_back.sv */
// back end: emits the sign and digits of one queued entry, one beat a cycle,
// most significant first; depends on sitda_pkg
module sitda_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  sitda_pkg::entry_type   head_entry,
   output logic                   pop,
   output logic                   rsp_strobe,
   output logic [7:0]             rsp_character,
   output logic                   rsp_last
);
   import sitda_pkg::*;

   logic active_ff;
   logic sign_pend_ff;
   logic [DigitIndexWidth-1:0] idx_ff;
   digit_type digs_ff [MaxDigits];
   logic strobe_ff;
   logic [7:0] char_ff, char_in;
   logic last_ff, last_in;
   logic done_now;

   assign done_now = active_ff && !sign_pend_ff && (idx_ff == '0);
   assign pop = head_valid && (!active_ff || done_now);

   always_comb begin
      char_in = sign_pend_ff ? CharMinus : (CharZero + {4'b0000, digs_ff[idx_ff]});
      last_in = done_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= active_ff;
         if (pop) active_ff <= 1'b1;
         else if (done_now) active_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      if (pop) begin
         sign_pend_ff <= head_entry.neg;
         idx_ff <= head_entry.ndig - 1'b1;
         for (int i = 0; i < MaxDigits; i++) digs_ff[i] <= head_entry.digits[i];
      end else if (active_ff) begin
         // sign goes out first, then digits count down to the units place
         if (sign_pend_ff) sign_pend_ff <= 1'b0;
         else if (idx_ff != '0) idx_ff <= idx_ff - 1'b1;
      end
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_character = char_ff;
   assign rsp_last = last_ff;

endmodule

/* rtl/signed_int_to_decimal_ascii.sv */
// signed 32-bit integer to decimal ascii, one character beat per cycle while a
// value's text is emitted. the front divider does one reciprocal multiply per
// digit; the back emits n or n+1 beats per value, n = digit count.
// a two-entry queue lets the front take the next value while the back emits.
// synchronous active-high reset empties the queue and idles both ends.
module signed_int_to_decimal_ascii (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_value,
   output logic        rsp_strobe,
   output logic [7:0]  rsp_character,
   output logic        rsp_last
);
   import sitda_pkg::*;

   logic push, pop, queue_full, head_valid;
   entry_type push_entry, head_entry;

   sitda_front u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_value  (req_value),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   sitda_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   sitda_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (head_valid),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

endmodule

/* sim/tb_top.sv */
// testbench for signed_int_to_decimal_ascii: directed table, then random values
// each value's decimal text is typed in the table or predicted locally, and checked beat by beat
// depends on rtl/sitda_pkg.sv and rtl/signed_int_to_decimal_ascii.sv
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import sitda_pkg::*;

   localparam int RandomValues = 308;
   localparam int StallLimit = 2000;
   localparam int DrainCycles = 20;

   typedef struct packed {
      logic [7:0] character;
      logic       is_last;
   } text_beat_type;

   typedef struct {
      logic [31:0] value;
      string       text;  // empty: predicted
   } value_row_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [31:0] req_value;
   logic        rsp_strobe;
   logic [7:0]  rsp_character;
   logic        rsp_last;

   text_beat_type pending_chars[$];
   string         value_notes[$];
   int            error_count;
   int            stall_cycles;

   signed_int_to_decimal_ascii u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // expected decimal text of one value, most significant character first
   function automatic void predict_decimal_text(logic [31:0] value);
      logic        neg;
      logic [31:0] mag;
      digit_type   digits[MaxDigits];
      int          count;
      neg = value[31];
      mag = neg ? 32'd0 - value : value;
      count = 0;
      do begin
         digits[count] = digit_type'(mag % 32'd10);
         mag = mag / 32'd10;
         count++;
      end while (mag != 32'd0 && count < MaxDigits);
      if (neg) begin
         pending_chars.push_back('{character: CharMinus, is_last: 1'b0});
      end
      for (int i = count - 1; i >= 0; i--) begin
         pending_chars.push_back('{character: CharZero + {4'd0, digits[i]},
                                   is_last: (i == 0)});
      end
   endfunction

   function automatic void queue_typed_text(string text);
      for (int i = 0; i < text.len(); i++) begin
         pending_chars.push_back('{character: text[i], is_last: (i == text.len() - 1)});
      end
   endfunction

   // accept and result monitor, plus the stall watchdog
   always @(posedge clock) begin
      text_beat_type want;
      string         note;
      if (reset) begin
         stall_cycles <= 0;
      end else begin
         if (start && !busy) begin
            note = value_notes.pop_front();
            if (note.len() != 0) begin
               queue_typed_text(note);
            end else begin
               predict_decimal_text(req_value);
            end
         end
         if (rsp_strobe) begin
            if (pending_chars.size() == 0) begin
               $display("%0t: unexpected beat character %h last %b", $time,
                        rsp_character, rsp_last);
               error_count++;
            end else begin
               want = pending_chars.pop_front();
               if (rsp_character !== want.character) begin
                  $display("%0t: character expected %h got %h", $time,
                           want.character, rsp_character);
                  error_count++;
               end
               if (rsp_last !== want.is_last) begin
                  $display("%0t: last expected %b got %b", $time, want.is_last, rsp_last);
                  error_count++;
               end
            end
         end
         if ((start && !busy) || rsp_strobe) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= StallLimit) begin
            $display("%0t: no progress for %0d cycles", $time, StallLimit);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   function automatic logic [31:0] random_value();
      logic [31:0] v;
      longint      limit;
      int          k;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: begin
            k = $urandom_range(1, 9);
            limit = 1;
            repeat (k) limit = limit * 10;
            v = $urandom_range(0, 32'(limit - 1));
         end
         2: begin
            // around a power of ten, where the digit count changes
            k = $urandom_range(0, 9);
            limit = 1;
            repeat (k) limit = limit * 10;
            v = 32'(limit) - 32'($urandom_range(0, 1));
         end
         default: v = $urandom_range(0, 20);
      endcase
      if ($urandom_range(0, 1)) v = 32'd0 - v;
      return v;
   endfunction

   function automatic int random_gap(bit burst);
      if (burst || $urandom_range(0, 9) < 5) return 0;
      if ($urandom_range(0, 9) == 0) return $urandom_range(15, 60);
      return $urandom_range(1, 4);
   endfunction

   // drive one value and hold it until taken, then idle for the given gap
   task automatic send_value(logic [31:0] value, string text, int gap);
      value_notes.push_back(text);
      start <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      if (gap > 0) begin
         start <= 1'b0;
         req_value <= $urandom;
         repeat (gap) @(posedge clock);
      end
   endtask

   value_row_type directed_rows[] = '{
      '{32'd0,           "0"},
      '{32'd1,           "1"},
      '{-32'sd1,         "-1"},
      '{32'd9,           "9"},
      '{32'd10,          "10"},
      '{-32'sd10,        "-10"},
      '{32'd99,          ""},
      '{32'd100,         ""},
      '{32'h7FFF_FFFF,   "2147483647"},
      '{32'h8000_0000,   "-2147483648"},
      '{32'h8000_0001,   "-2147483647"},
      '{32'd1000000000,  "1000000000"},
      '{32'd999999999,   "999999999"},
      '{-32'sd999999999, ""},
      '{32'd1234567890,  ""},
      '{-32'sd1234567890, ""},
      '{32'h5555_5555,   ""},
      '{32'hAAAA_AAAA,   ""},
      '{32'd4294967286,  ""},
      '{32'd2147483640,  ""},
      '{32'd7,           ""},
      '{-32'sd5,         ""}
   };

   initial begin
      bit burst;
      error_count = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_value <= 32'd0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         send_value(directed_rows[i].value, directed_rows[i].text, random_gap(1'b0));
      end

      burst = 1'b0;
      for (int n = 0; n < RandomValues; n++) begin
         if (n % 40 == 0) burst = ($urandom_range(0, 2) == 0);
         send_value(random_value(), "", random_gap(burst));
      end
      start <= 1'b0;

      while (pending_chars.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
